>>> rtl/fsp_pkg.sv
// ============================================================================
// fsp_pkg : shared types and constants for the format spec flag parser
// Character codes, phase and target codes, result kinds and the saturating
// arithmetic helpers used by the parse core.
// ============================================================================
package fsp_pkg;

    // Width of the accumulated decimal values (width, zero pad, precision)
    localparam int VALUE_BITS = 31;
    // Width of the value fields on the result channel
    localparam int FIELD_W    = 31;

    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_STAR  = 8'h2A;  // '*'
    localparam logic [7:0] CH_DOT   = 8'h2E;  // '.'

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FLAGS  = 2'd1;
    localparam logic [1:0] PH_DIGITS = 2'd2;
    localparam logic [1:0] PH_ARG    = 2'd3;

    localparam logic [1:0] TG_WIDTH = 2'd0;
    localparam logic [1:0] TG_ZERO  = 2'd1;
    localparam logic [1:0] TG_PREC  = 2'd2;

    localparam logic [1:0] KIND_ARG  = 2'd0;
    localparam logic [1:0] KIND_SPEC = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    localparam logic       FUNC_CHAR = 1'b0;
    localparam logic       FUNC_ARG  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [7:0]  char_code;
        logic [31:0] arg_value;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               left_align;
        logic [FIELD_W-1:0] zero_width;
        logic [FIELD_W-1:0] field_width;
        logic [FIELD_W-1:0] precision_value;
        logic               precision_given;
        logic [7:0]         end_char;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // Magnitude of a signed 32-bit argument, saturated to VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] sat_mag(input logic [31:0] x);
        logic [31:0] mag;
        mag = x[31] ? (~x + 32'd1) : x;
        if ((mag >> VALUE_BITS) != 32'd0) begin
            return '1;
        end
        return mag[VALUE_BITS-1:0];
    endfunction

    // acc * 10 + d, saturated to VALUE_BITS
    function automatic logic [VALUE_BITS-1:0] acc_step(input logic [VALUE_BITS-1:0] acc,
                                                       input logic [3:0] d);
        logic [VALUE_BITS+3:0] sum;
        sum = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{VALUE_BITS{1'b0}}, d};
        if (sum[VALUE_BITS+3:VALUE_BITS] != 4'd0) begin
            return '1;
        end
        return sum[VALUE_BITS-1:0];
    endfunction

endpackage

>>> rtl/fsp_core.sv
// ============================================================================
// fsp_core : parse state and per-item decode
// Holds the parse state and, for each item handed in on go, computes the next
// state and the optional result in one pass of combinational logic.
// ============================================================================
module fsp_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            go,
    input  fsp_pkg::item_t  item,
    output logic            res_valid,
    output fsp_pkg::result_t res
);
    import fsp_pkg::*;

    logic [1:0]            phase_reg,      phase_next;
    logic [1:0]            target_reg,     target_next;
    logic [VALUE_BITS-1:0] acc_reg,        acc_next;
    logic                  left_reg,       left_next;
    logic [VALUE_BITS-1:0] zpad_reg,       zpad_next;
    logic [VALUE_BITS-1:0] width_reg,      width_next;
    logic [VALUE_BITS-1:0] prec_reg,       prec_next;
    logic                  prec_seen_reg,  prec_seen_next;

    logic [7:0]            c;
    logic [7:0]            dig8;
    logic [3:0]            dig;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic                  do_flag;
    logic                  do_commit;
    logic [VALUE_BITS-1:0] commit_val;

    assign c    = item.char_code;
    assign dig8 = c - CH_ZERO;
    assign dig  = dig8[3:0];
    assign neg  = item.arg_value[31];
    assign mag  = sat_mag(item.arg_value);

    always_comb begin
        phase_next     = phase_reg;
        target_next    = target_reg;
        acc_next       = acc_reg;
        left_next      = left_reg;
        zpad_next      = zpad_reg;
        width_next     = width_reg;
        prec_next      = prec_reg;
        prec_seen_next = prec_seen_reg;
        res_valid      = 1'b0;
        res            = '0;
        do_flag        = 1'b0;
        do_commit      = 1'b0;
        commit_val     = acc_reg;

        if (item.func == FUNC_ARG) begin
            if (phase_reg != PH_ARG) begin
                phase_next  = PH_IDLE;
                target_next = TG_WIDTH;
                res_valid   = 1'b1;
                res.kind    = KIND_ERR;
            end else begin
                case (target_reg)
                    TG_PREC: begin
                        if (!neg) begin
                            prec_next      = mag;
                            prec_seen_next = 1'b1;
                        end
                    end
                    TG_ZERO: begin
                        if (!neg) begin
                            zpad_next = mag;
                        end else begin
                            left_next  = 1'b1;
                            width_next = mag;
                        end
                    end
                    default: begin
                        if (neg) begin
                            left_next = 1'b1;
                        end
                        width_next = mag;
                    end
                endcase
                phase_next  = PH_FLAGS;
                target_next = TG_WIDTH;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    // introducer: clear all flags
                    phase_next     = PH_FLAGS;
                    target_next    = TG_WIDTH;
                    acc_next       = '0;
                    left_next      = 1'b0;
                    zpad_next      = '0;
                    width_next     = '0;
                    prec_next      = '0;
                    prec_seen_next = 1'b0;
                end
                PH_ARG: begin
                    phase_next  = PH_IDLE;
                    target_next = TG_WIDTH;
                    res_valid   = 1'b1;
                    res.kind    = KIND_ERR;
                end
                PH_DIGITS: begin
                    if (is_digit(c)) begin
                        acc_next = acc_step(acc_reg, dig);
                    end else begin
                        do_commit  = 1'b1;
                        commit_val = acc_reg;
                        do_flag    = 1'b1;
                    end
                end
                PH_FLAGS: begin
                    if (target_reg != TG_WIDTH) begin
                        if (c == CH_STAR) begin
                            phase_next = PH_ARG;
                            res_valid  = 1'b1;
                            res.kind   = KIND_ARG;
                        end else if (is_digit(c)) begin
                            phase_next = PH_DIGITS;
                            acc_next   = {{(VALUE_BITS-4){1'b0}}, dig};
                        end else begin
                            // lone '0' or '.' commits a zero value
                            do_commit  = 1'b1;
                            commit_val = '0;
                            do_flag    = 1'b1;
                        end
                    end else begin
                        do_flag = 1'b1;
                    end
                end
                default: ;
            endcase
        end

        if (do_commit) begin
            case (target_reg)
                TG_ZERO: zpad_next = commit_val;
                TG_PREC: begin
                    prec_next      = commit_val;
                    prec_seen_next = 1'b1;
                end
                default: width_next = commit_val;
            endcase
            phase_next  = PH_FLAGS;
            target_next = TG_WIDTH;
        end

        if (do_flag) begin
            if (c == CH_MINUS) begin
                left_next = 1'b1;
            end else if (c == CH_ZERO) begin
                target_next = TG_ZERO;
            end else if (c == CH_DOT) begin
                target_next = TG_PREC;
            end else if (c == CH_STAR) begin
                phase_next  = PH_ARG;
                target_next = TG_WIDTH;
                res_valid   = 1'b1;
                res.kind    = KIND_ARG;
            end else if (is_digit(c)) begin
                phase_next  = PH_DIGITS;
                target_next = TG_WIDTH;
                acc_next    = {{(VALUE_BITS-4){1'b0}}, dig};
            end else begin
                // left-justify moves the zero-pad width into the field width
                if (left_next && (zpad_next != '0)) begin
                    width_next = zpad_next;
                    zpad_next  = '0;
                end
                res_valid           = 1'b1;
                res.kind            = KIND_SPEC;
                res.left_align      = left_next;
                res.zero_width      = FIELD_W'(zpad_next);
                res.field_width     = FIELD_W'(width_next);
                res.precision_value = FIELD_W'(prec_next);
                res.precision_given = prec_seen_next;
                res.end_char        = c;
                phase_next          = PH_IDLE;
                target_next         = TG_WIDTH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            target_reg    <= TG_WIDTH;
            acc_reg       <= '0;
            left_reg      <= 1'b0;
            zpad_reg      <= '0;
            width_reg     <= '0;
            prec_reg      <= '0;
            prec_seen_reg <= 1'b0;
        end else if (go) begin
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            acc_reg       <= acc_next;
            left_reg      <= left_next;
            zpad_reg      <= zpad_next;
            width_reg     <= width_next;
            prec_reg      <= prec_next;
            prec_seen_reg <= prec_seen_next;
        end
    end

endmodule

>>> rtl/format_spec_flag_parser.sv
// ============================================================================
// format_spec_flag_parser : printf flag-part parser, one character per cycle unless m_ stalls
// Parses '-', '0', '*', '.' and decimal digit runs of a conversion spec and
// emits an argument request, the completed flags, or a protocol error.
// ============================================================================
//
//  channel | direction | tdata                         | tuser
//  --------+-----------+-------------------------------+-------------
//  s_      | in        | char_code, arg_value          | func
//  m_      | out       | left_align .. end_char        | kind
//
//  One item per cycle sustained while m_ does not stall; an accepted item waits
//  in the input register, and its result is loaded into the result register.
//  Parse state advances only when the input register hands its item to the
//  core, which happens when the result register is empty or being drained.
//  A stall on m_ holds the result; s_tready stays high while the input
//  register is empty or can hand off in the same cycle.
//  Synchronous active-low reset returns the parser to idle with flags clear.
//
module format_spec_flag_parser (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [39:0]  s_tdata,   // [7:0] char_code, [39:8] arg_value
    input  logic [0:0]   s_tuser,   // [0] func
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata,   // [0] left_align, [31:1] zero_width,
                                    // [62:32] field_width, [93:63] precision_value,
                                    // [94] precision_given, [102:95] end_char, [103] 0
    output logic [1:0]   m_tuser    // [1:0] kind
);
    import fsp_pkg::*;

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    advance;
    logic    res_valid;
    result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.func      <= s_tuser[0];
            in_item_reg.char_code <= s_tdata[7:0];
            in_item_reg.arg_value <= s_tdata[39:8];
        end
    end

    fsp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (advance),
        .item      (in_item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tdata  = {1'b0,
                       out_res_reg.end_char,
                       out_res_reg.precision_given,
                       out_res_reg.precision_value,
                       out_res_reg.field_width,
                       out_res_reg.zero_width,
                       out_res_reg.left_align};

endmodule

>>> rtl/fsp_checker.sv
// ============================================================================
// fsp_checker : port-level checks for the format spec flag parser
// Watches the ports for reset behavior, stall holding and the
// consistency of emitted flag sets.
// ============================================================================
module fsp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [103:0] m_tdata,
    input logic [1:0]   m_tuser
);
    import fsp_pkg::*;

    logic [7:0] end_c;
    logic       spec_out;

    assign end_c    = m_tdata[102:95];
    assign spec_out = m_tvalid && (m_tuser == KIND_SPEC);

    // no result may be pending right after reset, and the input is open
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && s_tready))
        else $error("result valid or input blocked after reset");

    // a stalled result holds
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // argument requests and errors carry an all-zero payload
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_ARG || m_tuser == KIND_ERR)) |-> (m_tdata == '0))
        else $error("non-spec result with payload");

    // left justify always absorbs the zero-pad width
    a_left_no_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (spec_out && m_tdata[0]) |-> (m_tdata[31:1] == '0))
        else $error("left justify with zero padding");

    // a spec never ends on a flag, star, dot or digit
    a_end_char: assert property (@(posedge aclk) disable iff (!aresetn)
        spec_out |-> !(end_c == CH_MINUS || end_c == CH_STAR || end_c == CH_DOT ||
                       is_digit(end_c)))
        else $error("spec ended on a flag character");

endmodule

bind format_spec_flag_parser fsp_checker u_fsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench : self-checking bench for format_spec_flag_parser
// Streams conversion specs and argument items into the parser and checks every
// result against a cycle-free model of the flag parser kept in a scoreboard.
// Both channels stall at random, with a stretch of full-rate traffic.
// ----------------------------------------------------------------------------
module testbench;
    import fsp_pkg::*;

    localparam int ITEMS = 1050;
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = '1;

    // Tracks the parse state and holds the results the parser owes us.
    class spec_tracker;
        logic [1:0]            phase;
        logic [1:0]            target;
        logic [VALUE_BITS-1:0] acc;
        logic [VALUE_BITS-1:0] zero_pad;
        logic [VALUE_BITS-1:0] min_width;
        logic [VALUE_BITS-1:0] precision;
        logic                  left_just;
        logic                  precision_seen;
        result_t               owed_q[$];
        int                    failures;

        function new();
            clear();
            failures = 0;
        endfunction

        function void clear();
            phase          = PH_IDLE;
            target         = TG_WIDTH;
            acc            = '0;
            zero_pad       = '0;
            min_width      = '0;
            precision      = '0;
            left_just      = 1'b0;
            precision_seen = 1'b0;
        endfunction

        function logic [VALUE_BITS-1:0] clamp(logic [63:0] v);
            return (v > 64'(VALUE_MAX)) ? VALUE_MAX : v[VALUE_BITS-1:0];
        endfunction

        function bit numeral(logic [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function void push_kind(logic [1:0] kind);
            result_t r;
            r      = '0;
            r.kind = kind;
            owed_q.push_back(r);
        endfunction

        // Close the pending digit run or prefix into its target.
        function void store(logic [VALUE_BITS-1:0] v);
            if (target == TG_ZERO) begin
                zero_pad = v;
            end else if (target == TG_PREC) begin
                precision      = v;
                precision_seen = 1'b1;
            end else begin
                min_width = v;
            end
            phase  = PH_FLAGS;
            target = TG_WIDTH;
        endfunction

        function void flag_char(logic [7:0] c);
            result_t r;
            if (c == CH_MINUS) begin
                left_just = 1'b1;
            end else if (c == CH_ZERO) begin
                target = TG_ZERO;
            end else if (c == CH_DOT) begin
                target = TG_PREC;
            end else if (c == CH_STAR) begin
                phase  = PH_ARG;
                target = TG_WIDTH;
                push_kind(KIND_ARG);
            end else if (numeral(c)) begin
                phase  = PH_DIGITS;
                target = TG_WIDTH;
                acc    = VALUE_BITS'(c - CH_ZERO);
            end else begin
                // left justify wins over zero padding
                if (left_just && zero_pad != 0) begin
                    min_width = zero_pad;
                    zero_pad  = '0;
                end
                r                 = '0;
                r.kind            = KIND_SPEC;
                r.left_align      = left_just;
                r.zero_width      = zero_pad;
                r.field_width     = min_width;
                r.precision_value = precision;
                r.precision_given = precision_seen;
                r.end_char        = c;
                owed_q.push_back(r);
                phase  = PH_IDLE;
                target = TG_WIDTH;
            end
        endfunction

        function void take_arg(logic [31:0] arg);
            logic                  neg;
            logic [31:0]           mag32;
            logic [VALUE_BITS-1:0] mag;
            neg   = arg[31];
            mag32 = neg ? -arg : arg;
            mag   = clamp({32'd0, mag32});
            if (target == TG_PREC) begin
                // negative precision is dropped
                if (!neg) begin
                    precision      = mag;
                    precision_seen = 1'b1;
                end
            end else if (target == TG_ZERO && !neg) begin
                zero_pad = mag;
            end else begin
                if (neg) begin
                    left_just = 1'b1;
                end
                min_width = mag;
            end
            phase  = PH_FLAGS;
            target = TG_WIDTH;
        endfunction

        function void accept_item(logic func, logic [7:0] c, logic [31:0] arg);
            if (func == FUNC_ARG) begin
                if (phase != PH_ARG) begin
                    phase  = PH_IDLE;
                    target = TG_WIDTH;
                    push_kind(KIND_ERR);
                end else begin
                    take_arg(arg);
                end
                return;
            end
            case (phase)
                PH_IDLE: begin
                    clear();
                    phase = PH_FLAGS;
                end
                PH_ARG: begin
                    phase  = PH_IDLE;
                    target = TG_WIDTH;
                    push_kind(KIND_ERR);
                end
                PH_DIGITS: begin
                    if (numeral(c)) begin
                        acc = clamp(64'(acc) * 64'd10 + 64'(c - CH_ZERO));
                    end else begin
                        store(acc);
                        flag_char(c);
                    end
                end
                default: begin
                    if (target != TG_WIDTH) begin
                        if (c == CH_STAR) begin
                            phase = PH_ARG;
                            push_kind(KIND_ARG);
                            return;
                        end
                        if (numeral(c)) begin
                            phase = PH_DIGITS;
                            acc   = VALUE_BITS'(c - CH_ZERO);
                            return;
                        end
                        store('0);
                    end
                    flag_char(c);
                end
            endcase
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, seen);
                failures++;
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [103:0] d);
            result_t want;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, kind);
                failures++;
                return;
            end
            want = owed_q.pop_front();
            compare("kind", 32'(want.kind), 32'(kind));
            compare("left_align", 32'(want.left_align), 32'(d[0]));
            compare("zero_width", 32'(want.zero_width), 32'(d[31:1]));
            compare("field_width", 32'(want.field_width), 32'(d[62:32]));
            compare("precision_value", 32'(want.precision_value), 32'(d[93:63]));
            compare("precision_given", 32'(want.precision_given), 32'(d[94]));
            compare("end_char", 32'(want.end_char), 32'(d[102:95]));
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [39:0]  s_tdata  = '0;
    logic [0:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic [1:0]   m_tuser;

    spec_tracker tracker = new();
    bit          steady  = 1'b0;
    int          sent    = 0;

    format_spec_flag_parser u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Called and returning at a falling edge.
    task automatic send_item(input logic func, input logic [7:0] ch, input logic [31:0] arg);
        logic [7:0]  c_field;
        logic [31:0] a_field;
        // fill the unused field with noise
        c_field = (func == FUNC_ARG) ? 8'($urandom) : ch;
        a_field = (func == FUNC_ARG) ? arg : $urandom;
        while (!steady && $urandom_range(0, 99) < 32) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {a_field, c_field};
        do @(posedge aclk); while (!s_tready);
        tracker.accept_item(func, c_field, a_field);
        sent++;
        @(negedge aclk);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(FUNC_CHAR, c, 32'd0);
    endtask

    task automatic send_arg(input logic [31:0] a);
        send_item(FUNC_ARG, 8'd0, a);
    endtask

    // Hold the input idle until every owed result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.owed_q.size() != 0);
    endtask

    function automatic logic [31:0] pick_arg();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return $urandom_range(0, 99);
            5:       return -$urandom_range(1, 99);
            default: return $urandom;
        endcase
    endfunction

    // Digit run, star with argument, or nothing after a '0' or '.' prefix.
    task automatic send_operand(input bit after_prefix);
        int r;
        int n;
        r = $urandom_range(0, 9);
        if (r < 2 && after_prefix) begin
            return;
        end
        if (r < 4) begin
            send_char(CH_STAR);
            // now and then skip the argument to break the sequence
            if ($urandom_range(0, 19) != 0) begin
                send_arg(pick_arg());
            end
            return;
        end
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 3);
        send_char(CH_ZERO + 8'(after_prefix ? $urandom_range(0, 9) : $urandom_range(1, 9)));
        repeat (n - 1) send_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    task automatic send_spec();
        logic [7:0] c;
        send_char(8'($urandom));
        repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 5))
                0: send_char(CH_MINUS);
                1: begin
                    send_char(CH_ZERO);
                    send_operand(1'b1);
                end
                2: send_operand(1'b0);
                3: begin
                    send_char(CH_DOT);
                    send_operand(1'b1);
                end
                4: send_char(CH_MINUS);
                default: begin
                    send_item(1'($urandom_range(0, 1)), 8'($urandom), $urandom);
                end
            endcase
        end
        do c = 8'($urandom);
        while (c == CH_MINUS || c == CH_STAR || c == CH_DOT || (c >= CH_ZERO && c <= CH_NINE));
        send_char(c);
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // argument with nothing waiting
        send_arg(32'h8000_0000);
        // left justify moves zero pad to width, negative star precision dropped
        send_char("%");
        send_char(CH_MINUS);
        send_char(CH_ZERO);
        send_char("5");
        send_char(CH_DOT);
        send_char(CH_STAR);
        send_arg(32'hFFFF_FFFF);
        send_char("d");
        // star after zero, most negative argument; lone dot; NUL ends the spec
        send_char("%");
        send_char(CH_ZERO);
        send_char(CH_STAR);
        send_arg(32'h8000_0000);
        send_char(CH_DOT);
        send_char(8'h00);
        // star after zero, largest argument; lone zero
        send_char("%");
        send_char(CH_ZERO);
        send_char(CH_STAR);
        send_arg(32'h7FFF_FFFF);
        send_char(CH_ZERO);
        send_char(8'hFF);
        // negative star width
        send_char("%");
        send_char(CH_STAR);
        send_arg(32'hFFFF_FFF9);
        send_char("s");
        // character while an argument is wanted
        send_char("%");
        send_char(CH_STAR);
        send_char("q");
        drain();

        while (sent < ITEMS) begin
            steady = (sent >= 500 && sent < 700);
            if (!drained && sent >= 300) begin
                drain();
                drained = 1'b1;
            end
            send_spec();
        end
        steady = 1'b0;

        drain();
        repeat (10) @(posedge aclk);
        if (tracker.failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    always @(negedge aclk) begin
        m_tready <= steady || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            tracker.check_result(m_tuser, m_tdata);
        end
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
